// ----- hw/rtl/pctd_pkg.sv -----
`timescale 1ns / 1ps

package pctd_pkg;

	localparam int MAX_NODES    = 512;
	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_BITS  = 8;

	localparam int NODE_AW = $clog2(MAX_NODES);
	localparam int USED_W  = $clog2(MAX_NODES + 1);

	localparam int FUNC_W = 2;
	localparam int SYM_W  = 8;
	localparam int BITS_W = 32;
	localparam int LEN_W  = 6;
	localparam int ERR_W  = 2;
	localparam int POS_W  = $clog2(BITS_W);

	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_DECODE = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE    = 2'd0,
		ERR_MISSING = 2'd1,
		ERR_FULL    = 2'd2
	} err_t;

	typedef struct packed {
		logic [NODE_AW-1:0]     left;
		logic [NODE_AW-1:0]     right;
		logic [SYMBOL_BITS-1:0] sym;
	} node_t;

	typedef struct packed {
		logic               sym_valid;
		logic [SYM_W-1:0]   symbol;
		logic [ERR_W-1:0]   error;
	} res_t;

	typedef struct packed {
		logic               re;
		logic [NODE_AW-1:0] raddr;
		logic               we;
		logic [NODE_AW-1:0] waddr;
		node_t              wdata;
	} mem_req_t;

endpackage

// ----- hw/rtl/pctd_node_ram.sv -----
`timescale 1ns / 1ps

module pctd_node_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 26
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/pctd_res_buf.sv -----
`timescale 1ns / 1ps

module pctd_res_buf import pctd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  res_t             push_res,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             symbol_valid,
	output logic [SYM_W-1:0] symbol,
	output logic [ERR_W-1:0] error
);

	res_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	res_t       head;

	assign out_valid    = (cnt_q != 2'd0);
	assign full         = (cnt_q == 2'd2);
	assign pop          = out_valid && !out_stall;
	assign head         = slot_q[rd_q];
	assign symbol_valid = head.sym_valid;
	assign symbol       = head.symbol;
	assign error        = head.error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_res;
		end
	end

endmodule

// ----- hw/rtl/pctd_walker.sv -----
`timescale 1ns / 1ps

module pctd_walker import pctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [SYM_W-1:0]  code_symbol,
	input  logic [BITS_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	input  logic              bit_req,
	input  logic              buf_full,
	output logic              res_push,
	output res_t              res,
	output mem_req_t          req,
	input  node_t             mem_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LD_STEP,
		ST_LD_FETCH,
		ST_DEC_WAIT
	} state_t;

	state_t                 state_q;
	logic [USED_W-1:0]      used_q;
	logic [NODE_AW-1:0]     cur_q;
	node_t                  cur_ent_q;
	node_t                  root_q;
	logic [NODE_AW-1:0]     node_q;
	node_t                  ent_q;
	logic [LEN_W-1:0]       rem_q;
	logic [BITS_W-1:0]      bits_q;
	logic [SYMBOL_BITS-1:0] sym_q;

	logic                   accept;
	logic [LEN_W-1:0]       rem_dec;
	logic                   code_bit;
	logic [NODE_AW-1:0]     slot;
	logic                   full;
	logic [NODE_AW-1:0]     fresh;
	logic [NODE_AW-1:0]     dec_next;
	logic                   leaf;
	node_t                  ent_alloc;

	assign in_stall = (state_q != ST_IDLE) || buf_full;
	assign accept   = in_valid && !in_stall;
	assign rem_dec  = rem_q - 1'b1;
	assign code_bit = (rem_dec < LEN_W'(BITS_W)) ? bits_q[rem_dec[POS_W-1:0]] : 1'b0;
	assign slot     = code_bit ? ent_q.right : ent_q.left;
	assign full     = (used_q == USED_W'(MAX_NODES));
	assign fresh    = used_q[NODE_AW-1:0];
	assign dec_next = bit_req ? cur_ent_q.right : cur_ent_q.left;
	assign leaf     = (mem_rdata.left == '0) && (mem_rdata.right == '0);

	always_comb begin
		ent_alloc = ent_q;
		if (code_bit) begin
			ent_alloc.right = fresh;
		end else begin
			ent_alloc.left = fresh;
		end
	end

	always_comb begin
		req      = '0;
		res_push = 1'b0;
		res      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_DECODE) begin
					if (dec_next == '0) begin
						res_push  = 1'b1;
						res.error = ERR_MISSING;
					end else begin
						req.re    = 1'b1;
						req.raddr = dec_next;
					end
				end else if (accept && func != FUNC_LOAD) begin
					res_push = 1'b1;
				end
			end
			ST_LD_STEP: begin
				if (rem_q == '0) begin
					req.we        = 1'b1;
					req.waddr     = node_q;
					req.wdata     = ent_q;
					req.wdata.sym = sym_q;
					res_push      = 1'b1;
				end else if (slot != '0) begin
					req.re    = 1'b1;
					req.raddr = slot;
				end else if (full) begin
					req.we    = 1'b1;
					req.waddr = node_q;
					req.wdata = ent_q;
					res_push  = 1'b1;
					res.error = ERR_FULL;
				end else begin
					req.we    = 1'b1;
					req.waddr = node_q;
					req.wdata = ent_alloc;
				end
			end
			ST_DEC_WAIT: begin
				res_push = 1'b1;
				if (leaf) begin
					res.sym_valid = 1'b1;
					res.symbol    = SYM_W'(mem_rdata.sym);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= USED_W'(1);
			cur_q     <= '0;
			cur_ent_q <= '0;
			root_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func_t'(func))
							FUNC_LOAD: begin
								state_q <= ST_LD_STEP;
							end
							FUNC_DECODE: begin
								if (dec_next == '0) begin
									cur_q     <= '0;
									cur_ent_q <= root_q;
								end else begin
									state_q <= ST_DEC_WAIT;
								end
							end
							FUNC_CLEAR: begin
								used_q    <= USED_W'(1);
								cur_q     <= '0;
								cur_ent_q <= '0;
								root_q    <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LD_STEP: begin
					if (rem_q == '0) begin
						state_q <= ST_IDLE;
					end else if (slot != '0) begin
						state_q <= ST_LD_FETCH;
					end else if (full) begin
						state_q <= ST_IDLE;
					end else begin
						used_q <= used_q + 1'b1;
					end
				end
				ST_LD_FETCH: begin
					state_q <= ST_LD_STEP;
				end
				ST_DEC_WAIT: begin
					state_q <= ST_IDLE;
					if (leaf) begin
						cur_q     <= '0;
						cur_ent_q <= root_q;
					end else begin
						cur_q     <= node_q;
						cur_ent_q <= mem_rdata;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (req.we && req.waddr == '0) begin
				root_q <= req.wdata;
			end
			if (req.we && req.waddr == cur_q) begin
				cur_ent_q <= req.wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					node_q <= (func == FUNC_LOAD) ? '0 : dec_next;
					ent_q  <= root_q;
					rem_q  <= (code_len > LEN_CAP) ? LEN_CAP : code_len;
					bits_q <= code_bits;
					sym_q  <= SYMBOL_BITS'(code_symbol);
				end
			end
			ST_LD_STEP: begin
				if (rem_q != '0) begin
					if (slot != '0) begin
						node_q <= slot;
						rem_q  <= rem_dec;
					end else if (!full) begin
						node_q <= fresh;
						ent_q  <= '0;
						rem_q  <= rem_dec;
					end
				end
			end
			ST_LD_FETCH: begin
				ent_q <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && used_q <= USED_W'(MAX_NODES))
		else $error("node count out of range");

	a_write_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> USED_W'(req.waddr) < used_q)
		else $error("write to unallocated node");

	a_fetch_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LD_FETCH |-> $past(req.re))
		else $error("fetch without node read");

	a_dec_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEC_WAIT |-> $past(state_q) == ST_IDLE && $past(req.re))
		else $error("decode wait without child read");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !buf_full)
		else $error("result beat with no buffer room");

endmodule

// ----- hw/rtl/prefix_code_tree_decoder_top.sv -----
`timescale 1ns / 1ps

// Prefix-code tree decoder. A load beat walks its code from the root and allocates
// missing nodes; a decode beat steps one bit down the tree and returns the symbol at
// a leaf; a clear beat resets to a bare root. Every input beat gives exactly one
// result beat. The node memory read is registered: a decode bit reads the chosen
// child and waits in ST_DEC_WAIT unless the child is missing; a load steps in
// ST_LD_STEP, reading into ST_LD_FETCH at each existing node and writing each new
// node. The root entry is held in registers, so no memory clearing pass follows
// reset or clear. Two results can be buffered, so input is taken while one waits.
module prefix_code_tree_decoder_top import pctd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [SYM_W-1:0]  code_symbol,
	input  logic [BITS_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_len,
	input  logic              bit_req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              symbol_valid,
	output logic [SYM_W-1:0]  symbol,
	output logic [ERR_W-1:0]  error
);

	mem_req_t req;
	node_t    mem_rdata;
	logic     res_push;
	res_t     res;
	logic     buf_full;

	pctd_node_ram #(
		.DEPTH(MAX_NODES),
		.WIDTH($bits(node_t))
	) u_ram (
		.clk  (clk),
		.re   (req.re),
		.raddr(req.raddr),
		.rdata(mem_rdata),
		.we   (req.we),
		.waddr(req.waddr),
		.wdata(req.wdata)
	);

	pctd_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.code_symbol(code_symbol),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.bit_req    (bit_req),
		.buf_full   (buf_full),
		.res_push   (res_push),
		.res        (res),
		.req        (req),
		.mem_rdata  (mem_rdata)
	);

	pctd_res_buf u_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (res_push),
		.push_res    (res),
		.full        (buf_full),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol_valid(symbol_valid),
		.symbol      (symbol),
		.error       (error)
	);

endmodule

// ----- sim/tb_prefix_code_tree_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_prefix_code_tree_decoder_top;
	import pctd_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
	localparam int                ITEMS    = 1900;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [FUNC_W-1:0] func        = FUNC_CLEAR;
	logic [SYM_W-1:0]  code_symbol = '0;
	logic [BITS_W-1:0] code_bits   = '0;
	logic [LEN_W-1:0]  code_len    = '0;
	logic              bit_req     = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              symbol_valid;
	logic [SYM_W-1:0]  symbol;
	logic [ERR_W-1:0]  error;

	logic [NODE_AW-1:0]     tree_left  [MAX_NODES];
	logic [NODE_AW-1:0]     tree_right [MAX_NODES];
	logic [SYMBOL_BITS-1:0] tree_sym   [MAX_NODES];
	int unsigned            tree_used;
	logic [NODE_AW-1:0]     walk_node;

	res_t decode_expect_q[$];
	int   mismatch_count = 0;
	int   beats_sent     = 0;
	int   hold_cycles    = 0;
	int   pend_gap       = 0;
	bit   send_idle_on   = 1'b1;
	bit   recv_idle_on   = 1'b1;

	prefix_code_tree_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.code_symbol  (code_symbol),
		.code_bits    (code_bits),
		.code_len     (code_len),
		.bit_req      (bit_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol_valid (symbol_valid),
		.symbol       (symbol),
		.error        (error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic void tree_reset();
		foreach (tree_left[i]) begin
			tree_left[i]  = '0;
			tree_right[i] = '0;
			tree_sym[i]   = '0;
		end
		tree_used = 1;
		walk_node = '0;
	endfunction

	function automatic res_t tree_predict(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s,
			logic [BITS_W-1:0] b, logic [LEN_W-1:0] l, logic r);
		res_t               res;
		int                 depth;
		logic [NODE_AW-1:0] node;
		logic [NODE_AW-1:0] nxt;
		logic               go_right;
		res = '0;
		case (f)
			FUNC_LOAD: begin
				depth = (l > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(l);
				node  = '0;
				for (int i = depth; i > 0 && res.error == ERR_NONE; i--) begin
					go_right = (i - 1 < BITS_W) ? b[i-1] : 1'b0;
					nxt      = go_right ? tree_right[node] : tree_left[node];
					if (nxt == '0) begin
						if (tree_used >= MAX_NODES) begin
							res.error = ERR_FULL;
						end else begin
							nxt             = NODE_AW'(tree_used);
							tree_left[nxt]  = '0;
							tree_right[nxt] = '0;
							tree_sym[nxt]   = '0;
							if (go_right)
								tree_right[node] = nxt;
							else
								tree_left[node] = nxt;
							tree_used++;
						end
					end
					node = nxt;
				end
				if (res.error == ERR_NONE)
					tree_sym[node] = s;
			end
			FUNC_DECODE: begin
				nxt = r ? tree_right[walk_node] : tree_left[walk_node];
				if (nxt == '0) begin
					res.error = ERR_MISSING;
					walk_node = '0;
				end else if (tree_left[nxt] == '0 && tree_right[nxt] == '0) begin
					res.sym_valid = 1'b1;
					res.symbol    = tree_sym[nxt];
					walk_node     = '0;
				end else begin
					walk_node = nxt;
				end
			end
			FUNC_CLEAR: tree_reset();
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_beat(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s,
			logic [BITS_W-1:0] b, logic [LEN_W-1:0] l, logic r);
		repeat (pend_gap) @(posedge clk);
		in_valid    <= 1'b1;
		func        <= f;
		code_symbol <= s;
		code_bits   <= b;
		code_len    <= l;
		bit_req     <= r;
		do @(posedge clk); while (in_stall);
		decode_expect_q.push_back(tree_predict(f, s, b, l, r));
		if (f != FUNC_NOP)
			beats_sent++;
		pend_gap = send_idle_on ? $urandom_range(16, 0) : 0;
		if (pend_gap > 0)
			in_valid <= 1'b0;
	endtask

	task automatic load_beat(logic [SYM_W-1:0] s, logic [BITS_W-1:0] b, logic [LEN_W-1:0] l);
		send_beat(FUNC_LOAD, s, b, l, 1'($urandom_range(1, 0)));
	endtask

	task automatic decode_beat(logic r);
		send_beat(FUNC_DECODE, 8'($urandom_range(255, 0)), $urandom(),
			6'($urandom_range(63, 0)), r);
	endtask

	task automatic clear_beat();
		send_beat(FUNC_CLEAR, 8'($urandom_range(255, 0)), $urandom(),
			6'($urandom_range(63, 0)), 1'($urandom_range(1, 0)));
	endtask

	task automatic decode_code(logic [BITS_W-1:0] b, logic [LEN_W-1:0] l);
		for (int i = int'(l); i > 0; i--)
			decode_beat(b[i-1]);
	endtask

	task automatic send_noise();
		logic [LEN_W-1:0] l;
		l = $urandom_range(1, 0) ? 6'($urandom_range(8, 0)) : 6'($urandom_range(63, 0));
		case ($urandom_range(19, 0))
			0, 1, 2, 3, 4, 5, 6, 7: decode_beat(1'($urandom_range(1, 0)));
			8, 9, 10, 11, 12, 13, 14, 15: load_beat(8'($urandom_range(255, 0)), $urandom(), l);
			16: clear_beat();
			default: send_beat(FUNC_NOP, 8'($urandom_range(255, 0)), $urandom(), l,
				1'($urandom_range(1, 0)));
		endcase
	endtask

	task automatic wait_results();
		int guard;
		if (pend_gap == 0)
			in_valid <= 1'b0;
		pend_gap = 0;
		guard    = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (decode_expect_q.size() != 0 && guard < 20000);
	endtask

	task automatic test_directed_codes();
		clear_beat();
		decode_beat(1'b0);
		load_beat(8'h00, 32'h0, 6'd0);
		load_beat(8'h41, 32'h0, 6'd1);
		load_beat(8'h42, 32'h2, 6'd2);
		load_beat(8'hFF, 32'hFFFF_FFFF, 6'd2);
		decode_code(32'h2, 6'd2);
		decode_code(32'h0, 6'd1);
		decode_code(32'h3, 6'd2);
		decode_beat(1'b1);
		load_beat(8'h7E, 32'h3, 6'd2);
		decode_beat(1'b1);
		load_beat(8'h10, 32'h1, 6'd1);
		decode_code(32'h2, 6'd2);
		send_beat(FUNC_NOP, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
		load_beat(8'h99, 32'hFFFF_FFFF, 6'h3F);
		decode_code(32'h6, 6'd3);
		clear_beat();
		decode_beat(1'b1);
	endtask

	task automatic test_store_full();
		logic [BITS_W-1:0] first_code;
		first_code = $urandom();
		clear_beat();
		load_beat(8'h5A, first_code, 6'h3F);
		while (tree_used < MAX_NODES)
			load_beat(8'($urandom_range(255, 0)), $urandom(), LEN_CAP);
		repeat (3) load_beat(8'($urandom_range(255, 0)), $urandom(), LEN_CAP);
		decode_code(first_code, LEN_CAP);
		load_beat(8'hA5, first_code, 6'd33);
		decode_code(first_code, LEN_CAP);
		clear_beat();
		decode_beat(1'b0);
	endtask

	task automatic test_backpressure();
		send_idle_on = 1'b0;
		clear_beat();
		load_beat(8'h11, 32'h0, 6'd1);
		load_beat(8'h22, 32'h2, 6'd2);
		load_beat(8'h33, 32'h3, 6'd2);
		wait_results();
		hold_cycles = 300;
		repeat (16) decode_beat(1'($urandom_range(1, 0)));
		load_beat(8'h44, 32'h7, 6'd3);
		decode_code(32'h7, 6'd3);
		wait_results();
		send_idle_on = 1'b1;
	endtask

	task automatic test_random_trees();
		logic [BITS_W-1:0] code_q [$];
		logic [LEN_W-1:0]  len_q [$];
		logic [SYM_W-1:0]  sym_q [$];
		logic [BITS_W-1:0] code;
		int                leaves;
		int                pick;
		int                skip;
		while (beats_sent < ITEMS) begin
			send_idle_on = ($urandom_range(3, 0) != 0);
			recv_idle_on = ($urandom_range(3, 0) != 0);
			if ($urandom_range(7, 0) == 0) begin
				repeat (40) send_noise();
			end else begin
				if ($urandom_range(9, 0) != 0)
					clear_beat();
				code_q.delete();
				len_q.delete();
				sym_q.delete();
				code_q.push_back('0);
				len_q.push_back('0);
				leaves = $urandom_range(24, 2);
				while (code_q.size() < leaves) begin
					pick = ($urandom_range(3, 0) == 0) ? code_q.size() - 1 :
						$urandom_range(code_q.size() - 1, 0);
					if (len_q[pick] < LEN_CAP) begin
						code = code_q[pick] << 1;
						code_q[pick] = code;
						len_q[pick]  = len_q[pick] + 1'b1;
						code_q.push_back(code | 1'b1);
						len_q.push_back(len_q[pick]);
					end
				end
				skip = ($urandom_range(4, 0) == 0) ? $urandom_range(leaves - 1, 0) : -1;
				foreach (code_q[k]) begin
					sym_q.push_back(8'($urandom_range(255, 0)));
					if (k != skip)
						load_beat(sym_q[k], code_q[k] | (BITS_W'($urandom()) << len_q[k]),
							len_q[k]);
				end
				repeat ($urandom_range(30, 5)) begin
					pick = $urandom_range(leaves - 1, 0);
					if ($urandom_range(15, 0) == 0)
						send_noise();
					decode_code(code_q[pick], len_q[pick]);
				end
			end
		end
	endtask

	initial begin : result_sink
		int   stall_left;
		res_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (decode_expect_q.size() == 0) begin
					$display("%0t: unexpected result symbol_valid=%0b symbol=%0h error=%0d",
						$time, symbol_valid, symbol, error);
					mismatch_count++;
				end else begin
					want = decode_expect_q.pop_front();
					if (symbol_valid !== want.sym_valid) begin
						$display("%0t: symbol_valid expected %0b actual %0b",
							$time, want.sym_valid, symbol_valid);
						mismatch_count++;
					end
					if (symbol !== want.symbol) begin
						$display("%0t: symbol expected %0h actual %0h",
							$time, want.symbol, symbol);
						mismatch_count++;
					end
					if (error !== want.error) begin
						$display("%0t: error expected %0d actual %0d",
							$time, want.error, error);
						mismatch_count++;
					end
				end
				stall_left = recv_idle_on ? $urandom_range(16, 0) : 0;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		tree_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_codes();
		wait_results();
		test_store_full();
		wait_results();
		test_backpressure();
		test_random_trees();
		wait_results();
		if (decode_expect_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, decode_expect_q.size());
			mismatch_count++;
		end
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_node_ram.sv
hw/rtl/pctd_res_buf.sv
hw/rtl/pctd_walker.sv
hw/rtl/prefix_code_tree_decoder_top.sv
sim/tb_prefix_code_tree_decoder_top.sv
